@@ sv/rmq_pkg.sv @@
package rmq_pkg;

    // Width of every matrix element and quaternion component.
    localparam int DATA_W  = 16;
    // Width of a sum or difference of two elements.
    localparam int NUM_W   = DATA_W + 1;
    // Number of components that come from a division.
    localparam int N_LANES = 3;

    // Branch of the conversion: trace, or the largest diagonal element.
    typedef enum logic [1:0] {
        BR_T,
        BR_X,
        BR_Y,
        BR_Z
    } t_branch;

    // One input beat: the matrix in storage order.
    typedef struct packed {
        logic signed [DATA_W-1:0] elem_0;
        logic signed [DATA_W-1:0] elem_1;
        logic signed [DATA_W-1:0] elem_2;
        logic signed [DATA_W-1:0] elem_3;
        logic signed [DATA_W-1:0] elem_4;
        logic signed [DATA_W-1:0] elem_5;
        logic signed [DATA_W-1:0] elem_6;
        logic signed [DATA_W-1:0] elem_7;
        logic signed [DATA_W-1:0] elem_8;
    } t_elems;

    // One result beat.
    typedef struct packed {
        logic signed [DATA_W-1:0] quat_x;
        logic signed [DATA_W-1:0] quat_y;
        logic signed [DATA_W-1:0] quat_z;
        logic signed [DATA_W-1:0] quat_w;
    } t_quat;

    // Signed width of the root argument before clamping.
    function automatic int arg_w(input int frac);
        return ((DATA_W > frac) ? DATA_W : frac) + 3;
    endfunction

    // Width of the radicand, the clamped argument scaled by one.
    function automatic int rad_w(input int frac);
        return arg_w(frac) - 1 + frac;
    endfunction

    // Number of root bits, one per square-root stage.
    function automatic int sq_bits(input int frac);
        return (rad_w(frac) + 1) / 2;
    endfunction

    // Width of the rounded root.
    function automatic int root_w(input int frac);
        return sq_bits(frac) + 1;
    endfunction

endpackage

@@ sv/rmq_front.sv @@
module rmq_front #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  rmq_pkg::t_elems                        i_elems,
    output logic                                   o_valid,
    output logic [rmq_pkg::rad_w(FRAC_BITS)-1:0]   o_rad,
    output rmq_pkg::t_branch                       o_branch,
    output logic signed [rmq_pkg::NUM_W-1:0]       o_num [rmq_pkg::N_LANES]
);
    import rmq_pkg::*;

    localparam int AW  = arg_w(FRAC_BITS);
    localparam int RDW = rad_w(FRAC_BITS);

    logic signed [AW-1:0]    a00, a11, a22, trace, arg, one;
    logic signed [NUM_W-1:0] dx, dy, dz, sxy, sxz, syz;

    logic                    r_valid;
    logic [RDW-1:0]          r_rad, n_rad;
    t_branch                 r_branch, n_branch;
    logic signed [NUM_W-1:0] r_num [N_LANES];
    logic signed [NUM_W-1:0] n_num [N_LANES];

    // Branch choice, root argument and the three numerators.
    always_comb begin
        a00   = AW'(i_elems.elem_0);
        a11   = AW'(i_elems.elem_4);
        a22   = AW'(i_elems.elem_8);
        one   = AW'(1) <<< FRAC_BITS;
        trace = a00 + a11 + a22;

        dx  = NUM_W'(i_elems.elem_5) - NUM_W'(i_elems.elem_7);
        dy  = NUM_W'(i_elems.elem_6) - NUM_W'(i_elems.elem_2);
        dz  = NUM_W'(i_elems.elem_1) - NUM_W'(i_elems.elem_3);
        sxy = NUM_W'(i_elems.elem_3) + NUM_W'(i_elems.elem_1);
        sxz = NUM_W'(i_elems.elem_6) + NUM_W'(i_elems.elem_2);
        syz = NUM_W'(i_elems.elem_7) + NUM_W'(i_elems.elem_5);

        if (trace > 0) begin
            n_branch = BR_T;
        end else if (a00 > a11 && a00 > a22) begin
            n_branch = BR_X;
        end else if (a11 > a22) begin
            n_branch = BR_Y;
        end else begin
            n_branch = BR_Z;
        end

        // Lanes hold the non-main components in x, y, z, w order.
        case (n_branch)
            BR_X: begin
                arg = one + a00 - a11 - a22;
                n_num[0] = sxy; n_num[1] = sxz; n_num[2] = dx;
            end
            BR_Y: begin
                arg = one + a11 - a00 - a22;
                n_num[0] = sxy; n_num[1] = syz; n_num[2] = dy;
            end
            BR_Z: begin
                arg = one + a22 - a00 - a11;
                n_num[0] = sxz; n_num[1] = syz; n_num[2] = dz;
            end
            default: begin
                arg = trace + one;
                n_num[0] = dx; n_num[1] = dy; n_num[2] = dz;
            end
        endcase

        // A non-positive argument is clamped to one LSB.
        if (arg <= 0) begin
            arg = AW'(1);
        end
        n_rad = {arg[AW-2:0], {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad    <= n_rad;
        r_branch <= n_branch;
        r_num    <= n_num;
    end

    assign o_valid  = r_valid;
    assign o_rad    = r_rad;
    assign o_branch = r_branch;
    assign o_num    = r_num;

endmodule

@@ sv/rmq_sqrt.sv @@
module rmq_sqrt #(
    parameter int FRAC_BITS = 14,
    parameter int PAY_W     = 1
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic [rmq_pkg::rad_w(FRAC_BITS)-1:0]    i_rad,
    input  logic [PAY_W-1:0]                        i_pay,
    output logic                                    o_valid,
    output logic [rmq_pkg::root_w(FRAC_BITS)-1:0]   o_root,
    output logic [PAY_W-1:0]                        o_pay
);
    import rmq_pkg::*;

    localparam int SB  = sq_bits(FRAC_BITS);
    localparam int RTW = root_w(FRAC_BITS);
    localparam int TW  = 2 * SB + 2;

    logic             r_v    [SB+1];
    logic [TW-1:0]    r_rem  [SB+1];
    logic [SB-1:0]    r_root [SB+1];
    logic [PAY_W-1:0] r_pay  [SB+1];

    logic             r_out_v;
    logic [RTW-1:0]   r_out_root;
    logic [PAY_W-1:0] r_out_pay;

    // Entry stage: remainder starts as the radicand, root as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= TW'(i_rad);
        r_root[0] <= '0;
        r_pay[0]  <= i_pay;
    end

    // One root bit per stage, most significant first.
    for (genvar k = 0; k < SB; k++) begin : g_stage
        localparam int B = SB - 1 - k;
        logic [TW-1:0] trial;
        logic          fit;

        assign trial = (TW'(r_root[k]) << (B + 1)) + (TW'(1) << (2 * B));
        assign fit   = r_rem[k] >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= fit ? (r_rem[k] - trial) : r_rem[k];
            r_root[k+1] <= r_root[k] | ({{(SB-1){1'b0}}, fit} << B);
            r_pay[k+1]  <= r_pay[k];
        end
    end

    // Round to nearest: step up when the remainder exceeds the root.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[SB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_root <= RTW'(r_root[SB]) + RTW'(r_rem[SB] > TW'(r_root[SB]));
        r_out_pay  <= r_pay[SB];
    end

    assign o_valid = r_out_v;
    assign o_root  = r_out_root;
    assign o_pay   = r_out_pay;

endmodule

@@ sv/rmq_div.sv @@
module rmq_div #(
    parameter int FRAC_BITS = 14,
    parameter int PAY_W     = 1
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic [rmq_pkg::root_w(FRAC_BITS)-1:0]   i_root,
    input  logic signed [rmq_pkg::NUM_W-1:0]        i_num [rmq_pkg::N_LANES],
    input  logic [PAY_W-1:0]                        i_pay,
    output logic                                    o_valid,
    output logic signed [rmq_pkg::DATA_W-1:0]       o_quot [rmq_pkg::N_LANES],
    output logic [PAY_W-1:0]                        o_pay
);
    import rmq_pkg::*;

    localparam int RTW = root_w(FRAC_BITS);
    localparam int QB  = DATA_W;
    localparam int MW  = NUM_W;
    localparam int DW  = ((MW + FRAC_BITS > RTW) ? MW + FRAC_BITS : RTW) + 1;
    localparam int XW  = ((DW > RTW + 1 + QB) ? DW : RTW + 1 + QB) + 1;
    localparam logic [QB-1:0] SMAX = {1'b0, {(QB-1){1'b1}}};
    localparam logic [QB-1:0] SMIN = {1'b1, {(QB-1){1'b0}}};

    logic             r_v   [QB+1];
    logic [XW-1:0]    r_dsr [QB+1];
    logic [PAY_W-1:0] r_pay [QB+1];
    logic [XW-1:0]    r_rem [QB+1][N_LANES];
    logic [QB-1:0]    r_quo [QB+1][N_LANES];
    logic             r_neg [QB+1][N_LANES];
    logic             r_ovf [QB+1][N_LANES];

    logic [MW-1:0]    mag   [N_LANES];
    logic [XW-1:0]    dvd   [N_LANES];
    logic [XW-1:0]    dsr;

    logic                     r_out_v;
    logic [PAY_W-1:0]         r_out_pay;
    logic signed [DATA_W-1:0] r_out [N_LANES];
    logic signed [DATA_W-1:0] n_out [N_LANES];

    // Entry: magnitude, rounded dividend, divisor 2r and the overflow check.
    always_comb begin
        dsr = XW'(i_root) << 1;
        for (int l = 0; l < N_LANES; l++) begin
            mag[l] = i_num[l][NUM_W-1] ? MW'(-i_num[l]) : MW'(i_num[l]);
            dvd[l] = (XW'(mag[l]) << FRAC_BITS) + XW'(i_root);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dsr[0] <= dsr;
        r_pay[0] <= i_pay;
        for (int l = 0; l < N_LANES; l++) begin
            r_rem[0][l] <= dvd[l];
            r_quo[0][l] <= '0;
            r_neg[0][l] <= i_num[l][NUM_W-1];
            r_ovf[0][l] <= dvd[l] >= (dsr << QB);
        end
    end

    // Restoring division, one quotient bit per stage in each lane.
    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int B = QB - 1 - k;
        logic [XW-1:0] sub;

        assign sub = r_dsr[k] << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dsr[k+1] <= r_dsr[k];
            r_pay[k+1] <= r_pay[k];
            for (int l = 0; l < N_LANES; l++) begin
                r_neg[k+1][l] <= r_neg[k][l];
                r_ovf[k+1][l] <= r_ovf[k][l];
                if (r_rem[k][l] >= sub) begin
                    r_rem[k+1][l] <= r_rem[k][l] - sub;
                    r_quo[k+1][l] <= r_quo[k][l] | (QB'(1) << B);
                end else begin
                    r_rem[k+1][l] <= r_rem[k][l];
                    r_quo[k+1][l] <= r_quo[k][l];
                end
            end
        end
    end

    // Apply the sign and saturate to the output range.
    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            if (r_ovf[QB][l]) begin
                n_out[l] = r_neg[QB][l] ? SMIN : SMAX;
            end else if (!r_neg[QB][l]) begin
                n_out[l] = (r_quo[QB][l] > SMAX) ? SMAX : r_quo[QB][l];
            end else begin
                n_out[l] = (r_quo[QB][l] > SMIN) ? SMIN : DATA_W'(-r_quo[QB][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_out_pay <= r_pay[QB];
    end

    assign o_valid = r_out_v;
    assign o_quot  = r_out;
    assign o_pay   = r_out_pay;

endmodule

@@ sv/rotation_matrix_to_quaternion.sv @@
// Converts one 3x3 rotation matrix (Q1.14, storage order) into a quaternion
// (x, y, z, w) by Shepperd's branch method. A new matrix may be started in
// every clock cycle; o_busy is always low. Each result appears on o_data for
// exactly one cycle with o_valid high. Each matrix passes through one front
// stage, one square-root stage per root bit ((max(DATA_W, FRAC_BITS) +
// FRAC_BITS + 3) / 2, plus entry and rounding), one divider stage per
// output bit (16, plus entry and saturation) and the output register. The
// receiver must take every result in the cycle it is shown; there is no
// way to hold results off.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  rmq_pkg::t_elems i_data,
    output logic            o_busy,
    output logic            o_valid,
    output rmq_pkg::t_quat  o_data
);
    import rmq_pkg::*;

    localparam int RDW   = rad_w(FRAC_BITS);
    localparam int RTW   = root_w(FRAC_BITS);
    localparam int SB    = sq_bits(FRAC_BITS);
    localparam int QB    = DATA_W;
    localparam int PAY_S = 2 + N_LANES * NUM_W;
    localparam int PAY_D = 2 + RTW;
    localparam int CW    = ((RTW > DATA_W) ? RTW : DATA_W) + 1;
    localparam int LAT   = 1 + (SB + 2) + (QB + 2) + 1;
    localparam logic [CW-1:0] SMAX_W = CW'({1'b0, {(DATA_W-1){1'b1}}});

    logic                     accept;
    logic                     f_valid;
    logic [RDW-1:0]           f_rad;
    t_branch                  f_branch;
    logic signed [NUM_W-1:0]  f_num [N_LANES];

    logic [PAY_S-1:0]         s_pay_in, s_pay_out;
    logic                     s_valid;
    logic [RTW-1:0]           s_root;
    logic signed [NUM_W-1:0]  s_num [N_LANES];
    logic [RTW-1:0]           s_half;

    logic [PAY_D-1:0]         d_pay_in, d_pay_out;
    logic                     d_valid;
    logic signed [DATA_W-1:0] d_quot [N_LANES];
    t_branch                  d_branch;
    logic [RTW-1:0]           d_half;
    logic signed [DATA_W-1:0] main_q;

    logic                     r_valid;
    t_quat                    r_quat, n_quat;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_elems  (i_data),
        .o_valid  (f_valid),
        .o_rad    (f_rad),
        .o_branch (f_branch),
        .o_num    (f_num)
    );

    // Branch and numerators ride along with the root.
    assign s_pay_in = {f_branch, f_num[0], f_num[1], f_num[2]};

    rmq_sqrt #(.FRAC_BITS(FRAC_BITS), .PAY_W(PAY_S)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_rad   (f_rad),
        .i_pay   (s_pay_in),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_pay   (s_pay_out)
    );

    // Main component is half the root, rounded half up.
    always_comb begin
        s_num[0] = s_pay_out[3*NUM_W-1:2*NUM_W];
        s_num[1] = s_pay_out[2*NUM_W-1:NUM_W];
        s_num[2] = s_pay_out[NUM_W-1:0];
        s_half   = RTW'(((RTW+1)'(s_root) + (RTW+1)'(1)) >> 1);
    end

    assign d_pay_in = {s_pay_out[PAY_S-1:PAY_S-2], s_half};

    rmq_div #(.FRAC_BITS(FRAC_BITS), .PAY_W(PAY_D)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .i_root  (s_root),
        .i_num   (s_num),
        .i_pay   (d_pay_in),
        .o_valid (d_valid),
        .o_quot  (d_quot),
        .o_pay   (d_pay_out)
    );

    // Place the main component and the three quotients by branch.
    always_comb begin
        d_branch = t_branch'(d_pay_out[PAY_D-1:PAY_D-2]);
        d_half   = d_pay_out[RTW-1:0];
        if (CW'(d_half) > SMAX_W) begin
            main_q = SMAX_W[DATA_W-1:0];
        end else begin
            main_q = DATA_W'(d_half);
        end
        case (d_branch)
            BR_X: begin
                n_quat.quat_x = main_q;    n_quat.quat_y = d_quot[0];
                n_quat.quat_z = d_quot[1]; n_quat.quat_w = d_quot[2];
            end
            BR_Y: begin
                n_quat.quat_x = d_quot[0]; n_quat.quat_y = main_q;
                n_quat.quat_z = d_quot[1]; n_quat.quat_w = d_quot[2];
            end
            BR_Z: begin
                n_quat.quat_x = d_quot[0]; n_quat.quat_y = d_quot[1];
                n_quat.quat_z = main_q;    n_quat.quat_w = d_quot[2];
            end
            default: begin
                n_quat.quat_x = d_quot[0]; n_quat.quat_y = d_quot[1];
                n_quat.quat_z = d_quot[2]; n_quat.quat_w = main_q;
            end
        endcase
    end

    // Output register: each beat is shown for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quat <= n_quat;
    end

    assign o_valid = r_valid;
    assign o_data  = r_quat;

    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    // Every accepted matrix yields its result after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_valid)
        else $error("result missing at expected latency");

    // Each item from the root stage leaves the divider after the divider's fixed depth.
    a_div_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_valid |-> ##(QB + 2) d_valid)
        else $error("divider lost an item");

endmodule

@@ tb/quat_checker.sv @@
module quat_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  rmq_pkg::t_elems i_data,
    input  logic            i_valid,
    input  rmq_pkg::t_quat  i_quat,
    output int              o_errors,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rmq_pkg::*;

    localparam int FRAC = 14;
    localparam longint ONE = 64'sd1 <<< FRAC;

    t_quat quat_queue[$];
    int    errors = 0;

    assign o_errors  = errors;
    assign o_pending = quat_queue.size();

    // Nearest-integer square root, bit by bit.
    function automatic longint unsigned isqrt_round(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        if (n > res) res++;
        return res;
    endfunction

    // Computes n * ONE / (2r), rounded half away from zero.
    function automatic longint div_round(input longint n, input longint unsigned r);
        longint unsigned mag;
        longint unsigned q;
        mag = (n < 0) ? longint'(-n) : longint'(n);
        q   = ((mag << FRAC) + r) / (r << 1);
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [DATA_W-1:0] clip(input longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[DATA_W-1:0];
    endfunction

    // Shepperd conversion of one matrix.
    function automatic t_quat convert_matrix(input t_elems m);
        longint  a[9];
        longint  trace, arg, half, qx, qy, qz, qw;
        longint unsigned r;
        t_branch br;
        t_quat   q;
        a[0] = m.elem_0; a[1] = m.elem_1; a[2] = m.elem_2;
        a[3] = m.elem_3; a[4] = m.elem_4; a[5] = m.elem_5;
        a[6] = m.elem_6; a[7] = m.elem_7; a[8] = m.elem_8;
        trace = a[0] + a[4] + a[8];
        if (trace > 0) begin
            br  = BR_T;
            arg = trace + ONE;
        end else if (a[0] > a[4] && a[0] > a[8]) begin
            br  = BR_X;
            arg = ONE + a[0] - a[4] - a[8];
        end else if (a[4] > a[8]) begin
            br  = BR_Y;
            arg = ONE + a[4] - a[0] - a[8];
        end else begin
            br  = BR_Z;
            arg = ONE + a[8] - a[0] - a[4];
        end
        if (arg <= 0) arg = 1;
        r    = isqrt_round(longint'(arg) << FRAC);
        half = longint'((r + 1) >> 1);
        case (br)
            BR_T: begin
                qw = half;
                qx = div_round(a[5] - a[7], r);
                qy = div_round(a[6] - a[2], r);
                qz = div_round(a[1] - a[3], r);
            end
            BR_X: begin
                qx = half;
                qw = div_round(a[5] - a[7], r);
                qy = div_round(a[3] + a[1], r);
                qz = div_round(a[6] + a[2], r);
            end
            BR_Y: begin
                qy = half;
                qw = div_round(a[6] - a[2], r);
                qx = div_round(a[3] + a[1], r);
                qz = div_round(a[7] + a[5], r);
            end
            default: begin
                qz = half;
                qw = div_round(a[1] - a[3], r);
                qx = div_round(a[6] + a[2], r);
                qy = div_round(a[7] + a[5], r);
            end
        endcase
        q.quat_x = clip(qx);
        q.quat_y = clip(qy);
        q.quat_z = clip(qz);
        q.quat_w = clip(qw);
        return q;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t: mismatch on %s: got %0d, expected %0d",
                 $realtime, what, $signed(got), $signed(want));
        errors++;
    endtask

    // Watch both channels at every edge.
    always @(posedge i_clk) begin
        t_quat want;
        if (i_rst_n && i_valid) begin
            if (quat_queue.size() == 0) begin
                $display("%0t: result beat with no matrix outstanding", $realtime);
                errors++;
            end else begin
                want = quat_queue.pop_front();
                if (i_quat.quat_x !== want.quat_x)
                    report_mismatch("quat_x", i_quat.quat_x, want.quat_x);
                if (i_quat.quat_y !== want.quat_y)
                    report_mismatch("quat_y", i_quat.quat_y, want.quat_y);
                if (i_quat.quat_z !== want.quat_z)
                    report_mismatch("quat_z", i_quat.quat_z, want.quat_z);
                if (i_quat.quat_w !== want.quat_w)
                    report_mismatch("quat_w", i_quat.quat_w, want.quat_w);
            end
        end
        if (i_rst_n && i_start && !i_busy)
            quat_queue.push_back(convert_matrix(i_data));
    end
endmodule

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rmq_pkg::*;

    localparam int LATENCY   = 38;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_RANDOM  = 830;

    logic   clk = 0;
    logic   rst_n = 0;
    logic   start = 0;
    t_elems elems = '0;
    logic   busy, valid;
    t_quat  quat;
    int     errors, pending;
    int     idle_cycles = 0;

    always #2 clk = ~clk;

    rotation_matrix_to_quaternion DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_data(elems),
        .o_busy(busy), .o_valid(valid), .o_data(quat)
    );

    quat_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_data(elems), .i_valid(valid), .i_quat(quat),
        .o_errors(errors), .o_pending(pending)
    );

    // Watchdog on cycles where nothing moves.
    always @(posedge clk) begin
        if ((start && !busy) || valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] rnd_elem();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'(16384);
            2: return 16'(-16384);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // Builds a matrix with random content, with ties on the diagonal made more likely.
    function automatic t_elems rnd_matrix();
        t_elems m;
        m.elem_0 = rnd_elem(); m.elem_1 = rnd_elem(); m.elem_2 = rnd_elem();
        m.elem_3 = rnd_elem(); m.elem_4 = rnd_elem(); m.elem_5 = rnd_elem();
        m.elem_6 = rnd_elem(); m.elem_7 = rnd_elem(); m.elem_8 = rnd_elem();
        if ($urandom_range(0, 3) == 0) begin
            m.elem_4 = m.elem_0;
            if ($urandom_range(0, 1)) m.elem_8 = m.elem_0;
        end
        return m;
    endfunction

    // Drives one beat, after a random gap when gaps is set; start stays high across back-to-back beats.
    task automatic send_matrix(input t_elems m, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        elems <= m;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    function automatic t_elems diag(input int a, input int b, input int c,
                                    input int off);
        t_elems m;
        m = '0;
        m.elem_0 = 16'(a); m.elem_4 = 16'(b); m.elem_8 = 16'(c);
        m.elem_1 = 16'(off); m.elem_3 = 16'(-off); m.elem_2 = 16'(off);
        m.elem_6 = 16'(off + 3); m.elem_5 = 16'(-off); m.elem_7 = 16'(off);
        return m;
    endfunction

    initial begin
        t_elems m;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: identity, every branch, ties, extremes.
        send_matrix(diag(16384, 16384, 16384, 0), 0);
        send_matrix(diag(16384, -16384, -16384, 100), 0);
        send_matrix(diag(-16384, 16384, -16384, -200), 1);
        send_matrix(diag(-16384, -16384, 16384, 300), 0);
        send_matrix(diag(0, 0, 0, 0), 1);
        send_matrix(diag(-5, -5, -5, 7), 0);
        send_matrix(diag(-100, -100, -200, 16384), 0);
        send_matrix(diag(-100, -200, -200, -16384), 0);
        send_matrix(diag(-16384, -16384, -16384, 16384), 0);
        send_matrix(diag(-16384, -16384, -16384, -16384), 1);
        send_matrix(diag(1, 0, 0, 5), 0);
        m = '1;
        send_matrix(m, 0);
        m = {9{16'h8000}};
        send_matrix(m, 0);
        m = {9{16'h7fff}};
        send_matrix(m, 1);
        m = {9{16'h5555}};
        send_matrix(m, 0);
        m = {9{16'haaaa}};
        send_matrix(m, 0);
        m = diag(-32768, 32767, -32768, 32767);
        send_matrix(m, 0);

        // Hold off until the pipeline has drained; the extra edge lets the
        // checker record the last beat before the count is read.
        start <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        for (int i = 0; i < N_RANDOM; i++)
            send_matrix(rnd_matrix(), (i / 100) % 2 == 0);
        start <= 0;
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
sv/rmq_pkg.sv
sv/rmq_front.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion.sv
tb/quat_checker.sv
tb/testbench.sv
